/* rtl/fnsrc_pkg.sv */
`default_nettype none
package fnsrc_pkg;

	localparam int unsigned FREQ_W = 33;
	localparam int unsigned PFD_W  = 25;
	localparam int unsigned WORD_W = 32;
	localparam int unsigned IDX_W  = 3;
	localparam int unsigned CODE_W = 3;
	localparam int unsigned INT_W  = 16;
	localparam int unsigned MOD_W  = 12;
	localparam int unsigned FRAC_W = 12;
	localparam int unsigned PROD_W = 2 * PFD_W;

	// output divider thresholds in hertz
	localparam logic [FREQ_W-1:0] HZ_T2200 = 33'd2200000000;
	localparam logic [FREQ_W-1:0] HZ_T1100 = 33'd1100000000;
	localparam logic [FREQ_W-1:0] HZ_T550  = 33'd550000000;
	localparam logic [FREQ_W-1:0] HZ_T275  = 33'd275000000;
	localparam logic [FREQ_W-1:0] HZ_T137  = 33'd137500000;
	localparam logic [FREQ_W-1:0] HZ_T68   = 33'd68750000;

	localparam logic [PFD_W-1:0] PFD_RESET     = 25'd10000000;
	localparam logic [PFD_W-1:0] SPACING_RESET = 25'd100000;

	// field positions in the register words
	localparam int unsigned R0_INT_LSB  = 15;
	localparam int unsigned R0_FRAC_LSB = 3;
	localparam int unsigned R1_MOD_LSB  = 3;
	localparam int unsigned R1_FIX_BIT  = 27;
	localparam int unsigned R2_LD_LSB   = 26;
	localparam int unsigned R4_DIV_LSB  = 20;
	localparam logic [2:0]  R2_LD_CODE  = 3'b110;

	typedef enum logic [IDX_W-1:0] {
		CFG_PFD     = 3'd0,
		CFG_SPACING = 3'd1,
		CFG_REG2    = 3'd2,
		CFG_REG3    = 3'd3,
		CFG_REG4    = 3'd4,
		CFG_REG5    = 3'd5
	} cfg_idx_t;

	localparam logic [IDX_W-1:0] REG_R0 = 3'd0;
	localparam logic [IDX_W-1:0] REG_R1 = 3'd1;
	localparam logic [IDX_W-1:0] REG_R2 = 3'd2;
	localparam logic [IDX_W-1:0] REG_R3 = 3'd3;
	localparam logic [IDX_W-1:0] REG_R4 = 3'd4;
	localparam logic [IDX_W-1:0] REG_R5 = 3'd5;

endpackage
`default_nettype wire

/* rtl/fnsrc_divider.sv */
`default_nettype none
module fnsrc_divider #(
	parameter int unsigned NUM_W  = 33,
	parameter int unsigned DEN_W  = 25,
	parameter int unsigned SIDE_W = 8,
	parameter int unsigned BPS    = 4
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire logic [NUM_W-1:0]  num,
	input  wire logic [DEN_W-1:0]  den,
	input  wire logic [SIDE_W-1:0] side_in,
	output logic                   out_valid,
	output logic [NUM_W-1:0]       quo,
	output logic [DEN_W-1:0]       rem,
	output logic [SIDE_W-1:0]      side_out
);

	localparam int unsigned STAGES = (NUM_W + BPS - 1) / BPS;
	localparam int unsigned PAD_W  = STAGES * BPS;

	logic              vld_s [0:STAGES];
	logic [PAD_W-1:0]  num_s [0:STAGES];
	logic [PAD_W-1:0]  quo_s [0:STAGES];
	logic [DEN_W-1:0]  rem_s [0:STAGES];
	logic [DEN_W-1:0]  den_s [0:STAGES];
	logic [SIDE_W-1:0] side_s[0:STAGES];

	assign vld_s[0]  = in_valid;
	assign num_s[0]  = PAD_W'(num);
	assign quo_s[0]  = '0;
	assign rem_s[0]  = '0;
	assign den_s[0]  = den;
	assign side_s[0] = side_in;

	for (genvar g = 0; g < STAGES; g++) begin : g_stage
		logic [PAD_W-1:0] n_nx, q_nx;
		logic [DEN_W-1:0] r_nx;

		// restoring division, BPS quotient bits per stage, msb first
		always_comb begin
			logic [DEN_W:0] t;
			n_nx = num_s[g];
			q_nx = quo_s[g];
			r_nx = rem_s[g];
			for (int b = 0; b < BPS; b++) begin
				t = {r_nx, n_nx[PAD_W-1]};
				n_nx = {n_nx[PAD_W-2:0], 1'b0};
				if (t >= {1'b0, den_s[g]}) begin
					t = t - {1'b0, den_s[g]};
					q_nx = {q_nx[PAD_W-2:0], 1'b1};
				end else begin
					q_nx = {q_nx[PAD_W-2:0], 1'b0};
				end
				r_nx = t[DEN_W-1:0];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g+1] <= 1'b0;
			end else begin
				vld_s[g+1] <= vld_s[g];
			end
		end

		always_ff @(posedge clk) begin
			num_s[g+1]  <= n_nx;
			quo_s[g+1]  <= q_nx;
			rem_s[g+1]  <= r_nx;
			den_s[g+1]  <= den_s[g];
			side_s[g+1] <= side_s[g];
		end
	end

	assign out_valid = vld_s[STAGES];
	assign quo       = quo_s[STAGES][NUM_W-1:0];
	assign rem       = rem_s[STAGES];
	assign side_out  = side_s[STAGES];

endmodule
`default_nettype wire

/* rtl/frac_n_synth_register_calc.sv */
`default_nettype none
// Fractional-N register calculator. A request (start while busy is low) carries the
// wanted RF frequency in hertz; the six register words R5 down to R0 then come out
// back to back, each marked by word_valid, with last_word on R0 and range_error on
// all six. The receiver cannot hold words off. The math runs in a pipeline of
// radix-16 restoring dividers and one multiplier, but the six-word output sets the
// rate: busy stays high after each accepted request, and no request is taken while
// busy. Configuration must be written only while idle; the block does not enforce it.
module frac_n_synth_register_calc
	import fnsrc_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	output logic                          busy,
	input  wire logic [FREQ_W-1:0]        rf_freq_hz,
	input  wire logic                     cfg_we,
	input  wire logic [IDX_W-1:0]         cfg_index,
	input  wire logic [WORD_W-1:0]        cfg_data,
	output logic                          word_valid,
	output logic [WORD_W-1:0]             reg_word,
	output logic [IDX_W-1:0]              reg_index,
	output logic                          last_word,
	output logic                          range_error
);

	localparam int unsigned SIDE_C_W = INT_W + MOD_W + 1 + CODE_W;

	logic [PFD_W-1:0]  pfd_q, spacing_q;
	logic [WORD_W-1:0] reg2_q, reg3_q, reg4_q, reg5_q;
	logic [2:0]        busy_cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pfd_q     <= PFD_RESET;
			spacing_q <= SPACING_RESET;
			reg2_q    <= '0;
			reg3_q    <= '0;
			reg4_q    <= '0;
			reg5_q    <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_PFD:     pfd_q     <= cfg_data[PFD_W-1:0];
				CFG_SPACING: spacing_q <= cfg_data[PFD_W-1:0];
				CFG_REG2:    reg2_q    <= cfg_data;
				CFG_REG3:    reg3_q    <= cfg_data;
				CFG_REG4:    reg4_q    <= cfg_data;
				CFG_REG5:    reg5_q    <= cfg_data;
				default:     ;
			endcase
		end
	end

	logic accept;
	assign accept = start && !busy;
	assign busy   = (busy_cnt_q != 3'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_cnt_q <= 3'd0;
		end else if (accept) begin
			busy_cnt_q <= 3'd5;
		end else if (busy) begin
			busy_cnt_q <= busy_cnt_q - 3'd1;
		end
	end

	// stage 1: divider choice, scaled frequency
	logic [CODE_W-1:0] code;
	always_comb begin
		code = 3'd0;
		if (rf_freq_hz < HZ_T2200) code = 3'd1;
		if (rf_freq_hz < HZ_T1100) code = 3'd2;
		if (rf_freq_hz < HZ_T550)  code = 3'd3;
		if (rf_freq_hz < HZ_T275)  code = 3'd4;
		if (rf_freq_hz < HZ_T137)  code = 3'd5;
		if (rf_freq_hz < HZ_T68)   code = 3'd6;
	end

	logic              valid_s1;
	logic [FREQ_W-1:0] v_s1;
	logic [CODE_W-1:0] code_s1;
	logic [PFD_W-1:0]  pfd_s1, sp_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	// below 2200 MHz the scaled value stays under 4400 MHz, so 33 bits hold it
	always_ff @(posedge clk) begin
		v_s1    <= rf_freq_hz << code;
		code_s1 <= code;
		pfd_s1  <= (pfd_q == '0) ? PFD_W'(1) : pfd_q;
		sp_s1   <= (spacing_q == '0) ? PFD_W'(1) : spacing_q;
	end

	// INT and remainder, MOD alongside with equal latency
	logic              valid_a;
	logic [FREQ_W-1:0] int_a, mod_a;
	logic [PFD_W-1:0]  rem_a, pfd_a, rem_b_unused;
	logic [CODE_W-1:0] code_b;

	fnsrc_divider #(
		.NUM_W(FREQ_W), .DEN_W(PFD_W), .SIDE_W(PFD_W), .BPS(4)
	) u_div_int (
		.clk(clk), .arst_n(arst_n),
		.in_valid(valid_s1), .num(v_s1), .den(pfd_s1), .side_in(pfd_s1),
		.out_valid(valid_a), .quo(int_a), .rem(rem_a), .side_out(pfd_a)
	);

	fnsrc_divider #(
		.NUM_W(FREQ_W), .DEN_W(PFD_W), .SIDE_W(CODE_W), .BPS(4)
	) u_div_mod (
		.clk(clk), .arst_n(arst_n),
		.in_valid(valid_s1), .num(FREQ_W'(pfd_s1)), .den(sp_s1), .side_in(code_s1),
		.out_valid(), .quo(mod_a), .rem(rem_b_unused), .side_out(code_b)
	);

	// stage 2: range check, trim
	logic              valid_s2, err_s2;
	logic [PFD_W-1:0]  rem_s2, mod_s2, pfd_s2;
	logic [INT_W-1:0]  int_s2;
	logic [CODE_W-1:0] code_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_a;
		end
	end

	always_ff @(posedge clk) begin
		rem_s2  <= rem_a;
		mod_s2  <= mod_a[PFD_W-1:0];
		pfd_s2  <= pfd_a;
		int_s2  <= int_a[INT_W-1:0];
		code_s2 <= code_b;
		err_s2  <= (int_a[FREQ_W-1:INT_W] != '0) || (mod_a[FREQ_W-1:MOD_W] != '0)
			|| (rem_b_unused != rem_b_unused);
	end

	// stage 3: remainder times modulus
	logic                valid_s3;
	logic [PROD_W-1:0]   prod_s3;
	logic [PFD_W-1:0]    pfd_s3;
	logic [SIDE_C_W-1:0] side_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		prod_s3 <= PROD_W'(rem_s2) * PROD_W'(mod_s2);
		pfd_s3  <= pfd_s2;
		side_s3 <= {int_s2, mod_s2[MOD_W-1:0], err_s2, code_s2};
	end

	logic                valid_c;
	logic [PROD_W-1:0]   frac_c;
	logic [PFD_W-1:0]    rem_c_unused;
	logic [SIDE_C_W-1:0] side_c;

	fnsrc_divider #(
		.NUM_W(PROD_W), .DEN_W(PFD_W), .SIDE_W(SIDE_C_W), .BPS(4)
	) u_div_frac (
		.clk(clk), .arst_n(arst_n),
		.in_valid(valid_s3), .num(prod_s3), .den(pfd_s3), .side_in(side_s3),
		.out_valid(valid_c), .quo(frac_c), .rem(rem_c_unused), .side_out(side_c)
	);

	// word sequencer: loaded once per request; busy holds the next request off
	logic [WORD_W-1:0] r0_q, r1_q;
	logic [CODE_W-1:0] code_q;
	logic              err_q, active_q;
	logic [IDX_W-1:0]  cnt_q;
	logic [INT_W-1:0]  int_c;
	logic [MOD_W-1:0]  mod_c;

	assign int_c = side_c[SIDE_C_W-1 -: INT_W];
	assign mod_c = side_c[CODE_W+1 +: MOD_W];

	always_ff @(posedge clk) begin
		if (valid_c) begin
			r0_q   <= (WORD_W'(int_c) << R0_INT_LSB)
				| (WORD_W'(frac_c[FRAC_W-1:0]) << R0_FRAC_LSB)
				| WORD_W'(rem_c_unused != rem_c_unused);
			r1_q   <= (WORD_W'(1) << R1_FIX_BIT) | (WORD_W'(mod_c) << R1_MOD_LSB)
				| WORD_W'(1);
			code_q <= side_c[CODE_W-1:0];
			err_q  <= side_c[CODE_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			cnt_q    <= REG_R5;
		end else if (valid_c) begin
			active_q <= 1'b1;
			cnt_q    <= REG_R5;
		end else if (active_q) begin
			if (cnt_q == REG_R0) begin
				active_q <= 1'b0;
			end
			cnt_q <= cnt_q - 3'd1;
		end
	end

	logic [WORD_W-1:0] word_sel;
	always_comb begin
		unique case (cnt_q)
			REG_R5:  word_sel = reg5_q;
			REG_R4:  word_sel = {reg4_q[WORD_W-1:R4_DIV_LSB+CODE_W], code_q,
				reg4_q[R4_DIV_LSB-1:0]};
			REG_R3:  word_sel = reg3_q;
			REG_R2:  word_sel = {reg2_q[WORD_W-1:R2_LD_LSB+3], R2_LD_CODE,
				reg2_q[R2_LD_LSB-1:0]};
			REG_R1:  word_sel = r1_q;
			REG_R0:  word_sel = r0_q;
			default: word_sel = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_valid <= 1'b0;
		end else begin
			word_valid <= active_q;
		end
	end

	always_ff @(posedge clk) begin
		reg_word    <= word_sel;
		reg_index   <= cnt_q;
		last_word   <= (cnt_q == REG_R0);
		range_error <= err_q;
	end

endmodule
`default_nettype wire

/* sim/testbench.sv */
`timescale 1ns / 1ps
module testbench;
	import fnsrc_pkg::*;

	typedef struct packed {
		logic [WORD_W-1:0] word;
		logic [IDX_W-1:0]  idx;
		logic              last;
		logic              err;
	} synth_word_t;

	localparam int unsigned WATCHDOG_LIMIT = 2000;
	localparam int unsigned DRAIN_CYCLES   = 60;

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	logic [FREQ_W-1:0] rf_freq_hz;
	logic              cfg_we;
	logic [IDX_W-1:0]  cfg_index;
	logic [WORD_W-1:0] cfg_data;
	logic              word_valid;
	logic [WORD_W-1:0] reg_word;
	logic [IDX_W-1:0]  reg_index;
	logic              last_word;
	logic              range_error;

	// shadow copy of the configuration registers
	logic [PFD_W-1:0]  pfd_hz;
	logic [PFD_W-1:0]  spacing_hz;
	logic [WORD_W-1:0] r2_base;
	logic [WORD_W-1:0] r3_val;
	logic [WORD_W-1:0] r4_base;
	logic [WORD_W-1:0] r5_val;

	logic [FREQ_W-1:0] freq_queue[$];
	synth_word_t       expected_words[$];
	int                mismatches;
	int                requests_sent;
	int                words_seen;
	int                idle_cycles;
	int                burst_left;
	int                gap_left;
	bit                stim_done;
	bit                timed_out;
	bit                stim_hold;
	bit                taken;

	frac_n_synth_register_calc DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.rf_freq_hz(rf_freq_hz), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .word_valid(word_valid), .reg_word(reg_word),
		.reg_index(reg_index), .last_word(last_word), .range_error(range_error)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [CODE_W-1:0] divider_code(input logic [FREQ_W-1:0] f);
		logic [CODE_W-1:0] c;
		c = 0;
		if (f < HZ_T2200) c = 1;
		if (f < HZ_T1100) c = 2;
		if (f < HZ_T550) c = 3;
		if (f < HZ_T275) c = 4;
		if (f < HZ_T137) c = 5;
		if (f < HZ_T68) c = 6;
		return c;
	endfunction

	task automatic predict_words(input logic [FREQ_W-1:0] f);
		logic [CODE_W-1:0] code;
		logic [63:0] pfd, sp, v, ival, rem, md, frac;
		logic err;
		logic [WORD_W-1:0] r0, r1, r2, r4;
		code = divider_code(f);
		pfd = (pfd_hz == 0) ? 64'd1 : 64'(pfd_hz);
		sp = (spacing_hz == 0) ? 64'd1 : 64'(spacing_hz);
		v = 64'(f) << code;
		ival = v / pfd;
		rem = v % pfd;
		md = pfd / sp;
		frac = (rem * md) / pfd;
		err = (ival > 65535) || (md > 4095);
		r0 = (WORD_W'(ival[INT_W-1:0]) << R0_INT_LSB)
			| (WORD_W'(frac[FRAC_W-1:0]) << R0_FRAC_LSB);
		r1 = (WORD_W'(1) << R1_FIX_BIT) | (WORD_W'(md[MOD_W-1:0]) << R1_MOD_LSB) | 1;
		r2 = r2_base;
		r2[R2_LD_LSB +: 3] = R2_LD_CODE;
		r4 = r4_base;
		r4[R4_DIV_LSB +: CODE_W] = code;
		expected_words.push_back('{r5_val, REG_R5, 1'b0, err});
		expected_words.push_back('{r4, REG_R4, 1'b0, err});
		expected_words.push_back('{r3_val, REG_R3, 1'b0, err});
		expected_words.push_back('{r2, REG_R2, 1'b0, err});
		expected_words.push_back('{r1, REG_R1, 1'b0, err});
		expected_words.push_back('{r0, REG_R0, 1'b1, err});
	endtask

	task automatic report_mismatch(input string what);
		$display("mismatch at %0t: %s", $time, what);
		mismatches++;
	endtask

	// track acceptance at the rising edge and refill at the falling edge
	always @(posedge clk) begin
		taken <= start && !busy && arst_n;
		if (start && !busy && arst_n) begin
			predict_words(rf_freq_hz);
			requests_sent++;
		end
	end

	// driver: bursts of back-to-back requests separated by random gaps
	always @(negedge clk) begin
		if (arst_n && !stim_hold) begin
			if (taken || !start) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					start <= 1'b0;
				end else if (freq_queue.size() > 0) begin
					rf_freq_hz <= freq_queue.pop_front();
					start <= 1'b1;
					if (burst_left > 0) begin
						burst_left <= burst_left - 1;
					end else begin
						burst_left <= $urandom_range(0, 12);
						gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
					end
				end else begin
					start <= 1'b0;
				end
			end
		end else begin
			start <= 1'b0;
		end
	end

	// monitor
	always @(posedge clk) begin
		synth_word_t got, exp_w;
		if (arst_n && word_valid) begin
			words_seen++;
			got = '{reg_word, reg_index, last_word, range_error};
			if (expected_words.size() == 0) begin
				report_mismatch($sformatf("unexpected word %h index %0d", reg_word, reg_index));
			end else begin
				exp_w = expected_words.pop_front();
				if (got.word !== exp_w.word)
					report_mismatch($sformatf("R%0d word %h, want %h", exp_w.idx, got.word, exp_w.word));
				if (got.idx !== exp_w.idx)
					report_mismatch($sformatf("index %0d, want %0d", got.idx, exp_w.idx));
				if (got.last !== exp_w.last)
					report_mismatch($sformatf("R%0d last_word %b", exp_w.idx, got.last));
				if (got.err !== exp_w.err)
					report_mismatch($sformatf("R%0d range_error %b", exp_w.idx, got.err));
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (!arst_n || word_valid || (start && !busy) || stim_hold)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT && !stim_done) begin
			timed_out = 1'b1;
			$display("watchdog expired at %0t", $time);
			$display("frac_n_synth_register_calc test failed");
			$finish;
		end
	end

	task automatic write_cfg(input cfg_idx_t idx, input logic [WORD_W-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			CFG_PFD:     pfd_hz = data[PFD_W-1:0];
			CFG_SPACING: spacing_hz = data[PFD_W-1:0];
			CFG_REG2:    r2_base = data;
			CFG_REG3:    r3_val = data;
			CFG_REG4:    r4_base = data;
			CFG_REG5:    r5_val = data;
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// block until every queued request has been taken and answered
	task automatic wait_idle;
		stim_hold = 1'b0;
		while (freq_queue.size() > 0 || start || busy || expected_words.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		stim_hold = 1'b1;
		@(negedge clk);
	endtask

	task automatic set_all(input logic [WORD_W-1:0] pfd, input logic [WORD_W-1:0] sp);
		write_cfg(CFG_PFD, pfd);
		write_cfg(CFG_SPACING, sp);
		write_cfg(CFG_REG2, $urandom());
		write_cfg(CFG_REG3, $urandom());
		write_cfg(CFG_REG4, $urandom());
		write_cfg(CFG_REG5, $urandom());
	endtask

	function automatic logic [FREQ_W-1:0] random_freq();
		logic [FREQ_W-1:0] f;
		case ($urandom_range(0, 9))
			0: f = {$urandom(), 1'($urandom())};
			1: f = HZ_T68 + FREQ_W'($urandom_range(0, 4)) - 2;
			2: f = $urandom_range(0, 68750000);
			default: f = 34375000 + FREQ_W'($urandom_range(0, 32'd2147483647)) * 2;
		endcase
		if (f > 33'd4400000000 && $urandom_range(0, 3) != 0) f = f % 33'd4400000000;
		return f;
	endfunction

	initial begin
		logic [FREQ_W-1:0] edges[$];
		int phase;
		arst_n = 1'b0;
		start = 1'b0;
		rf_freq_hz = '0;
		cfg_we = 1'b0;
		cfg_index = CFG_PFD;
		cfg_data = '0;
		stim_hold = 1'b1;
		stim_done = 1'b0;
		timed_out = 1'b0;
		mismatches = 0;
		requests_sent = 0;
		words_seen = 0;
		idle_cycles = 0;
		burst_left = 0;
		gap_left = 0;
		pfd_hz = PFD_RESET;
		spacing_hz = SPACING_RESET;
		r2_base = '0;
		r3_val = '0;
		r4_base = '0;
		r5_val = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: reset settings, divider thresholds and field extremes
		edges = '{0, 1, HZ_T68 - 1, HZ_T68, HZ_T137 - 1, HZ_T137, HZ_T275 - 1, HZ_T275,
			HZ_T550 - 1, HZ_T550, HZ_T1100 - 1, HZ_T1100, HZ_T2200 - 1, HZ_T2200,
			33'd4400000000, 33'd4400000001, '1, 33'd1234567891};
		foreach (edges[i]) freq_queue.push_back(edges[i]);
		wait_idle();

		// zero pfd and spacing taken as one, then max pfd with tiny spacing, all-ones writes, and equal pfd and spacing
		set_all(0, 0);
		freq_queue.push_back(33'd1000000000);
		freq_queue.push_back('1);
		wait_idle();
		set_all(32'h1FFFFFF, 1);
		freq_queue.push_back(33'd3000000000);
		freq_queue.push_back(33'd100);
		wait_idle();
		set_all(32'hFFFFFFFF, 32'h1FFFFFF);
		freq_queue.push_back(33'd2500000000);
		wait_idle();
		set_all(32000000, 32000000);
		write_cfg(CFG_REG2, '1);
		write_cfg(CFG_REG4, '1);
		freq_queue.push_back(33'd2199999999);
		wait_idle();

		// random phases, each under its own setting
		for (phase = 0; phase < 7; phase++) begin
			case (phase % 3)
				0: set_all($urandom_range(1000000, 32000000), $urandom_range(1000, 200000));
				1: set_all($urandom_range(1, 32000000), $urandom_range(1, 32000000));
				default: set_all(10000000, 100000);
			endcase
			repeat (37) freq_queue.push_back(random_freq());
			wait_idle();
		end

		stim_done = 1'b1;
		$display("requests: %0d, register words checked: %0d", requests_sent, words_seen);
		$display("configs covered zero, max and typical pfd/spacing plus all divider bands");
		if (mismatches == 0 && expected_words.size() == 0) begin
			$display("frac_n_synth_register_calc test passed");
		end else begin
			$display("frac_n_synth_register_calc test failed");
		end
		$finish;
	end

endmodule
